FILE: hw/rtl/lpdr_pkg.sv
// Shared types and constants for the length-prefix deframer.
package lpdr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd256;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DESYNC  = 1'b1;

    typedef enum logic [1:0] {
        PH_LOW     = 2'd0,
        PH_HIGH    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
        logic [LEN_W-1:0]  bad_length;
    } result_t;

endpackage

FILE: hw/rtl/length_prefix_deframer_resync.sv
// Top level of the length-prefix deframer with byte-wise resynchronization.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  input     | in_valid / in_ready    | rx_byte
//  output    | out_valid / out_ready  | kind, payload_byte, frame_last, bad_length
//  config    | cfg_we                 | cfg_wdata (max_length)
//
// One request is taken per cycle while in_ready is high; its result, if any, shows on
// the outputs the next cycle unless the output is stalled.
// The max_length compare and next frame state are combinational, ahead of the output register.
// Reset clears the frame state and loads max_length with 256.
// A stalled output fills one skid entry; in_ready drops only while that entry is held.
module length_prefix_deframer_resync (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lpdr_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [lpdr_pkg::BYTE_W-1:0] payload_byte,
    output logic                        frame_last,
    output logic [lpdr_pkg::LEN_W-1:0]  bad_length,
    input  logic                        cfg_we,
    input  logic [lpdr_pkg::LEN_W-1:0]  cfg_wdata
);

    logic              accept;
    logic              res_valid;
    lpdr_pkg::result_t res;
    lpdr_pkg::result_t out_data;

    assign accept = in_valid && in_ready;

    lpdr_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res       (res)
    );

    lpdr_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && res_valid),
        .push_data  (res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign kind         = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign frame_last   = out_data.frame_last;
    assign bad_length   = out_data.bad_length;

endmodule

FILE: hw/rtl/lpdr_parse.sv
// Header and payload parser: frame state, max_length register and result build.
module lpdr_parse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [lpdr_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                              cfg_we,
    input  logic [lpdr_pkg::LEN_W-1:0]        cfg_wdata,
    output logic                              res_valid,
    output lpdr_pkg::result_t                 res
);

    lpdr_pkg::phase_t                  phase_reg, phase_next;
    logic [lpdr_pkg::BYTE_W-1:0]       held_low_reg, held_low_next;
    logic [lpdr_pkg::LEN_W-1:0]        remaining_reg, remaining_next;
    logic [lpdr_pkg::LEN_W-1:0]        max_length_reg;
    logic [lpdr_pkg::LEN_W-1:0]        cand_len;

    assign cand_len = {rx_byte, held_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lpdr_pkg::PH_LOW;
            held_low_reg   <= '0;
            remaining_reg  <= '0;
            max_length_reg <= lpdr_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                held_low_reg  <= held_low_next;
                remaining_reg <= remaining_next;
            end
            if (cfg_we)
            begin
                max_length_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        held_low_next    = held_low_reg;
        remaining_next   = remaining_reg;
        res_valid        = 1'b0;
        res.kind         = lpdr_pkg::KIND_PAYLOAD;
        res.payload_byte = '0;
        res.frame_last   = 1'b0;
        res.bad_length   = '0;
        case (phase_reg)
            lpdr_pkg::PH_HIGH:
            begin
                if (cand_len == '0 || cand_len > max_length_reg)
                begin
                    // drop the first header byte, slide by one
                    held_low_next  = rx_byte;
                    res_valid      = 1'b1;
                    res.kind       = lpdr_pkg::KIND_DESYNC;
                    res.bad_length = cand_len;
                end
                else
                begin
                    remaining_next = cand_len;
                    phase_next     = lpdr_pkg::PH_PAYLOAD;
                end
            end
            lpdr_pkg::PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                if (remaining_reg <= lpdr_pkg::LEN_W'(1))
                begin
                    remaining_next = '0;
                    phase_next     = lpdr_pkg::PH_LOW;
                    res.frame_last = 1'b1;
                end
                else
                begin
                    remaining_next = remaining_reg - lpdr_pkg::LEN_W'(1);
                end
            end
            default:
            begin
                held_low_next = rx_byte;
                phase_next    = lpdr_pkg::PH_HIGH;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lpdr_outbuf.sv
// Two-entry result buffer: output register plus skid register.
module lpdr_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpdr_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lpdr_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    lpdr_pkg::result_t main_reg;
    lpdr_pkg::result_t skid_reg;
    logic              pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (pop || !main_valid_reg)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (pop || !main_valid_reg)
        begin
            if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

FILE: hw/rtl/lpdr_checker.sv
// Port-level checks for the deframer, bound to the top level.
module lpdr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        kind,
    input logic [lpdr_pkg::BYTE_W-1:0] payload_byte,
    input logic                        frame_last,
    input logic [lpdr_pkg::LEN_W-1:0]  bad_length
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
            && $stable(frame_last) && $stable(bad_length))
        else $error("output request changed while stalled");

    a_desync_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lpdr_pkg::KIND_DESYNC |-> !frame_last && payload_byte == '0)
        else $error("desync result carries payload fields");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lpdr_pkg::KIND_PAYLOAD |-> bad_length == '0)
        else $error("payload result carries a bad length");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("in_ready dropped without an output stall");

endmodule

bind length_prefix_deframer_resync lpdr_checker u_lpdr_checker (.*);
